// ----- design/boq_pkg.sv -----
// Shared types and constants for the bounded ordered queue.
package boq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int HANDLE_W      = 32;
    localparam int COUNT_W       = 5;
    localparam int LIMIT_W       = 5;
    localparam int OP_W          = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    typedef enum logic [OP_W-1:0] {
        OP_PUT    = 3'd0,
        OP_GET    = 3'd1,
        OP_POP    = 3'd2,
        OP_REMOVE = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAKE,
        S_SCAN,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [HANDLE_W-1:0] item_handle;
    } req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [HANDLE_W-1:0] item_out;
        logic [COUNT_W-1:0]  entry_count;
    } rsp_t;

endpackage

// ----- design/bounded_ordered_queue.sv -----
// Bounded ordered queue of handles: top level with config and output register.
// One request at a time: put, clear and refused requests go straight to the response
// state; get and pop pass a take state after one registered store read; remove scans
// from the head and, on a match with entries behind it, moves each of them one slot
// toward the head by a store read and write; a stalled result waits in the response state.
// Reset: asynchronous active-low; queue empty, head at zero, limit back to 16.
module bounded_ordered_queue #(
    parameter int DEPTH = boq_pkg::DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [boq_pkg::LIMIT_W-1:0] cfg_wr_data,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  boq_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output boq_pkg::rsp_t               rsp
);
    import boq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    // Capacity limit register; a value above the store depth is clamped
    // inside the sequencer.
    logic [LIMIT_W-1:0] limit_reg;

    // Output word register: parts the result side from the sequencer so the
    // next request can start while a result still waits.
    logic rsp_valid_reg;
    rsp_t rsp_reg;

    logic                res_valid;
    logic                res_taken;
    rsp_t                res;
    logic [IDX_W-1:0]    mem_addr;
    logic                mem_wr_en;
    logic [HANDLE_W-1:0] mem_wr_data;
    logic                mem_rd_en;
    logic [HANDLE_W-1:0] mem_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Take a new result whenever the output register is empty or draining.
    assign res_taken = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && res_taken)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Hold the word while stalled; load only on a fresh result.
    always_ff @(posedge clk)
    begin
        if (res_valid && res_taken)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    boq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .limit       (limit_reg),
        .mem_addr    (mem_addr),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res_taken   (res_taken),
        .res         (res)
    );

    boq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .addr    (mem_addr),
        .wr_en   (mem_wr_en),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_data (mem_rd_data)
    );

endmodule

// ----- design/boq_store.sv -----
// Handle storage: single address, one write and one registered read per cycle.
module boq_store #(
    parameter int DEPTH = boq_pkg::DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic [$clog2(DEPTH)-1:0]     addr,
    input  logic                         wr_en,
    input  logic [boq_pkg::HANDLE_W-1:0] wr_data,
    input  logic                         rd_en,
    output logic [boq_pkg::HANDLE_W-1:0] rd_data
);
    import boq_pkg::*;

    logic [HANDLE_W-1:0] entry_mem [DEPTH];
    logic [HANDLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/boq_ctrl.sv -----
// Request sequencer with the shared slot adder and handle comparator.
module boq_ctrl #(
    parameter int DEPTH = boq_pkg::DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  boq_pkg::req_t                req,
    input  logic [boq_pkg::LIMIT_W-1:0]  limit,
    output logic [$clog2(DEPTH)-1:0]     mem_addr,
    output logic                         mem_wr_en,
    output logic [boq_pkg::HANDLE_W-1:0] mem_wr_data,
    output logic                         mem_rd_en,
    input  logic [boq_pkg::HANDLE_W-1:0] mem_rd_data,
    output logic                         res_valid,
    input  logic                         res_taken,
    output boq_pkg::rsp_t                res
);
    import boq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

    state_t              state_reg,  state_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [IDX_W-1:0]    head_reg,   head_next;
    logic [CNT_W-1:0]    idx_reg,    idx_next;
    logic [OP_W-1:0]     op_reg,     op_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [HANDLE_W-1:0] item_reg,   item_next;
    status_t             status_reg, status_next;

    logic [CNT_W-1:0] offset;
    logic [SUM_W-1:0] slot_sum;
    logic [SUM_W-1:0] slot_wrap;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] count_dec;
    logic             full;
    logic             empty;
    logic             hit;

    // Shared slot unit: head plus offset, folded once into the store range.
    assign slot_sum  = SUM_W'(head_reg) + SUM_W'(offset);
    assign slot_wrap = (slot_sum >= DEPTH_S) ? (slot_sum - DEPTH_S) : slot_sum;
    assign mem_addr  = slot_wrap[IDX_W-1:0];

    assign idx_inc   = idx_reg + CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);
    assign empty     = (count_reg == '0);
    assign full      = (CMP_W'(count_reg) >= CMP_W'(limit))
                    || (SUM_W'(count_reg) >= DEPTH_S);
    assign hit       = (mem_rd_data == handle_reg);

    assign req_stall   = (state_reg != S_IDLE);
    assign mem_wr_data = (state_reg == S_SHIFT_WR) ? mem_rd_data : req.item_handle;

    assign res.status      = status_reg;
    assign res.item_out    = item_reg;
    assign res.entry_count = COUNT_W'(count_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        idx_next    = idx_reg;
        op_next     = op_reg;
        handle_next = handle_reg;
        item_next   = item_reg;
        status_next = status_reg;
        offset      = '0;
        mem_wr_en   = 1'b0;
        mem_rd_en   = 1'b0;
        res_valid   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req.op;
                    handle_next = req.item_handle;
                    item_next   = '0;
                    status_next = ST_DONE;
                    state_next  = S_RESP;
                    unique case (req.op)
                        OP_PUT:
                        begin
                            offset = count_reg;
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_wr_en  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_GET, OP_POP:
                        begin
                            offset = (req.op == OP_POP) ? count_dec : '0;
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en  = 1'b1;
                                state_next = S_TAKE;
                            end
                        end
                        OP_REMOVE:
                        begin
                            idx_next = '0;
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en  = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            head_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_TAKE:
            begin
                // Offset one gives the next head for a get.
                offset     = CNT_W'(1);
                item_next  = mem_rd_data;
                count_next = count_dec;
                if (op_reg == OP_GET)
                begin
                    head_next = mem_addr;
                end
                state_next = S_RESP;
            end

            S_SCAN:
            begin
                offset = idx_inc;
                if (idx_inc < count_reg)
                begin
                    mem_rd_en = 1'b1;
                end
                if (hit)
                begin
                    if (idx_inc < count_reg)
                    begin
                        state_next = S_SHIFT_WR;
                    end
                    else
                    begin
                        count_next = count_dec;
                        state_next = S_RESP;
                    end
                end
                else if (idx_inc < count_reg)
                begin
                    idx_next = idx_inc;
                end
                else
                begin
                    status_next = ST_MISSING;
                    state_next  = S_RESP;
                end
            end

            S_SHIFT_RD:
            begin
                offset     = idx_inc;
                mem_rd_en  = 1'b1;
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                // Move the following entry one slot toward the head.
                offset    = idx_reg;
                mem_wr_en = 1'b1;
                idx_next  = idx_inc;
                if ((SUM_W'(idx_inc) + SUM_W'(1)) < SUM_W'(count_reg))
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    count_next = count_dec;
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                res_valid = 1'b1;
                if (res_taken)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        op_reg     <= op_next;
        handle_reg <= handle_next;
        item_reg   <= item_next;
        status_reg <= status_next;
    end

endmodule

// ----- design/boq_checker.sv -----
// Port-level checks for the bounded ordered queue, bound to the top level.
module boq_checker #(
    parameter int DEPTH = boq_pkg::DEPTH_DEFAULT
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_stall,
    input logic                        rsp_valid,
    input logic                        rsp_stall,
    input boq_pkg::rsp_t               rsp
);
    import boq_pkg::*;

    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

    // A stalled result word holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result word changed while stalled");

    // One request at a time: the block is busy right after an accept.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while the previous one is in work");

    // Count never passes the store depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.entry_count <= DEPTH_C)
        else $error("entry count above depth");

    // Refused requests return no handle.
    a_refused_no_item: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_DONE) |-> rsp.item_out == '0)
        else $error("handle returned on a refused request");

endmodule

bind bounded_ordered_queue boq_checker #(
    .DEPTH (DEPTH)
) u_boq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp)
);
